[hdl/lld_pkg.sv]
`timescale 1ns / 1ps

package lld_pkg;

    localparam int COORD_W  = 32;
    localparam int DIFF_W   = COORD_W + 1;
    localparam int CROSS_W  = 2 * COORD_W + 1;
    localparam int LIMB_W   = 26;
    localparam int LIMBS    = 4;
    localparam int MUL_W    = LIMB_W * LIMBS;
    localparam int PP_W     = 2 * LIMB_W;
    localparam int PROD_W   = 2 * MUL_W;
    localparam int DEN_W    = 136;
    localparam int QUO_W    = 64;
    localparam int ROOT_W   = QUO_W / 2;
    localparam int GAP_W    = 32;
    localparam int MUL_LAT  = 7;
    localparam int DOT_LAT  = MUL_LAT + 2;

    typedef struct packed {
        logic signed [COORD_W-1:0] first_point_x;
        logic signed [COORD_W-1:0] first_point_y;
        logic signed [COORD_W-1:0] first_point_z;
        logic signed [COORD_W-1:0] first_dir_x;
        logic signed [COORD_W-1:0] first_dir_y;
        logic signed [COORD_W-1:0] first_dir_z;
        logic signed [COORD_W-1:0] second_point_x;
        logic signed [COORD_W-1:0] second_point_y;
        logic signed [COORD_W-1:0] second_point_z;
        logic signed [COORD_W-1:0] second_dir_x;
        logic signed [COORD_W-1:0] second_dir_y;
        logic signed [COORD_W-1:0] second_dir_z;
    } t_item;

    typedef struct packed {
        logic [GAP_W-1:0] line_gap;
        logic             lines_parallel;
    } t_result;

    typedef struct packed {
        logic valid;
        logic par;
    } t_side;

    typedef logic signed [MUL_W-1:0]  t_mop;
    typedef logic signed [PROD_W-1:0] t_prod;

endpackage

[hdl/lld_mul.sv]
`timescale 1ns / 1ps

// Signed multiplier built from 26x26 partial products and a registered adder tree.
module lld_mul (
    input  logic          i_clk,
    input  lld_pkg::t_mop i_a,
    input  lld_pkg::t_mop i_b,
    output lld_pkg::t_prod o_p
);
    localparam int MW     = lld_pkg::MUL_W;
    localparam int LW     = lld_pkg::LIMB_W;
    localparam int NL     = lld_pkg::LIMBS;
    localparam int PW     = lld_pkg::PP_W;
    localparam int HALF_W = PW + LW + 2;
    localparam int ROW_W  = PW + 3 * LW + 2;
    localparam int PAIR_W = ROW_W + LW + 1;
    localparam int OW     = lld_pkg::PROD_W;

    logic [MW-1:0]     r_ma;
    logic [MW-1:0]     r_mb;
    logic [5:0]        r_neg;
    logic [PW-1:0]     r_pp [NL][NL];
    logic [HALF_W-1:0] r_half [NL][2];
    logic [ROW_W-1:0]  r_row [NL];
    logic [PAIR_W-1:0] r_pair [2];
    logic [OW-1:0]     r_mag;
    lld_pkg::t_prod    r_p;

    always_ff @(posedge i_clk) begin
        r_ma  <= i_a[MW-1] ? (MW'(~i_a) + MW'(1)) : MW'(i_a);
        r_mb  <= i_b[MW-1] ? (MW'(~i_b) + MW'(1)) : MW'(i_b);
        r_neg <= {r_neg[4:0], i_a[MW-1] ^ i_b[MW-1]};
        for (int i = 0; i < NL; i++) begin
            for (int j = 0; j < NL; j++) begin
                r_pp[i][j] <= PW'(r_ma[i*LW +: LW]) * PW'(r_mb[j*LW +: LW]);
            end
        end
        for (int i = 0; i < NL; i++) begin
            for (int h = 0; h < 2; h++) begin
                r_half[i][h] <= HALF_W'(r_pp[i][2*h]) + (HALF_W'(r_pp[i][2*h+1]) << LW);
            end
        end
        for (int i = 0; i < NL; i++) begin
            r_row[i] <= ROW_W'(r_half[i][0]) + (ROW_W'(r_half[i][1]) << (2 * LW));
        end
        for (int h = 0; h < 2; h++) begin
            r_pair[h] <= PAIR_W'(r_row[2*h]) + (PAIR_W'(r_row[2*h+1]) << LW);
        end
        // The true product fits the output width, so the top bits dropped here are zero.
        r_mag <= OW'(r_pair[0]) + (OW'(r_pair[1]) << (2 * LW));
        r_p   <= r_neg[5] ? (~r_mag + OW'(1)) : r_mag;
    end

    assign o_p = r_p;

endmodule

[hdl/lld_dot.sv]
`timescale 1ns / 1ps

module lld_dot (
    input  logic           i_clk,
    input  lld_pkg::t_mop  i_a [3],
    input  lld_pkg::t_mop  i_b [3],
    output lld_pkg::t_prod o_dot
);
    lld_pkg::t_prod w_p [3];
    lld_pkg::t_prod r_sum01;
    lld_pkg::t_prod r_p2;
    lld_pkg::t_prod r_dot;

    for (genvar i = 0; i < 3; i++) begin : g_lane
        lld_mul u_mul (
            .i_clk (i_clk),
            .i_a   (i_a[i]),
            .i_b   (i_b[i]),
            .o_p   (w_p[i])
        );
    end

    always_ff @(posedge i_clk) begin
        r_sum01 <= w_p[0] + w_p[1];
        r_p2    <= w_p[2];
        r_dot   <= r_sum01 + r_p2;
    end

    assign o_dot = r_dot;

endmodule

[hdl/lld_div.sv]
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per stage, with an overflow check up front.
module lld_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  lld_pkg::t_side             i_side,
    input  logic [lld_pkg::PROD_W-1:0] i_num,
    input  logic [lld_pkg::DEN_W-1:0]  i_den,
    output lld_pkg::t_side             o_side,
    output logic [lld_pkg::QUO_W-1:0]  o_quo,
    output logic                       o_sat
);
    localparam int PW     = lld_pkg::PROD_W;
    localparam int DW     = lld_pkg::DEN_W;
    localparam int QW     = lld_pkg::QUO_W;
    localparam int STAGES = QW + 1;

    logic [PW-1:0]  r_rem  [STAGES];
    logic [DW-1:0]  r_den  [STAGES];
    logic [QW-1:0]  r_quo  [STAGES];
    logic           r_sat  [STAGES];
    lld_pkg::t_side r_side [STAGES];

    // A quotient that does not fit the quotient width saturates the result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side[0] <= '0;
        end else begin
            r_side[0] <= i_side;
        end
        r_rem[0] <= i_num;
        r_den[0] <= i_den;
        r_quo[0] <= '0;
        r_sat[0] <= i_num >= (PW'(i_den) << QW);
    end

    for (genvar k = 1; k < STAGES; k++) begin : g_step
        localparam int BIT = QW - k;
        logic [PW-1:0] w_trial;
        logic          w_ge;
        logic [QW-1:0] n_quo;

        always_comb begin
            w_trial    = PW'(r_den[k-1]) << BIT;
            w_ge       = r_rem[k-1] >= w_trial;
            n_quo      = r_quo[k-1];
            n_quo[BIT] = w_ge;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_side[k] <= '0;
            end else begin
                r_side[k] <= r_side[k-1];
            end
            r_rem[k] <= w_ge ? (r_rem[k-1] - w_trial) : r_rem[k-1];
            r_den[k] <= r_den[k-1];
            r_quo[k] <= n_quo;
            r_sat[k] <= r_sat[k-1];
        end
    end

    assign o_side = r_side[STAGES-1];
    assign o_quo  = r_quo[STAGES-1];
    assign o_sat  = r_sat[STAGES-1];

endmodule

[hdl/lld_sqrt.sv]
`timescale 1ns / 1ps

// Digit-by-digit square root, one root bit per stage.
module lld_sqrt (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  lld_pkg::t_side             i_side,
    input  logic [lld_pkg::QUO_W-1:0]  i_val,
    input  logic                       i_sat,
    output lld_pkg::t_side             o_side,
    output logic [lld_pkg::ROOT_W-1:0] o_root,
    output logic                       o_sat
);
    localparam int QW = lld_pkg::QUO_W;
    localparam int RW = lld_pkg::ROOT_W;
    localparam int TW = QW + 1;

    logic [QW-1:0]  r_rem  [RW];
    logic [RW-1:0]  r_root [RW];
    logic           r_sat  [RW];
    lld_pkg::t_side r_side [RW];

    for (genvar k = 0; k < RW; k++) begin : g_step
        localparam int BIT = RW - 1 - k;
        logic [QW-1:0]  w_rem;
        logic [RW-1:0]  w_root;
        logic           w_sat;
        lld_pkg::t_side w_side;
        logic [TW-1:0]  w_trial;
        logic           w_ge;
        logic [RW-1:0]  n_root;

        if (k == 0) begin : g_first
            assign w_rem  = i_val;
            assign w_root = '0;
            assign w_sat  = i_sat;
            assign w_side = i_side;
        end else begin : g_next
            assign w_rem  = r_rem[k-1];
            assign w_root = r_root[k-1];
            assign w_sat  = r_sat[k-1];
            assign w_side = r_side[k-1];
        end

        // Root bits so far all sit above this bit, so the two terms never overlap.
        always_comb begin
            w_trial     = (TW'(w_root) << (BIT + 1)) | (TW'(1) << (2 * BIT));
            w_ge        = TW'(w_rem) >= w_trial;
            n_root      = w_root;
            n_root[BIT] = w_ge;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_side[k] <= '0;
            end else begin
                r_side[k] <= w_side;
            end
            r_rem[k]  <= w_ge ? (w_rem - w_trial[QW-1:0]) : w_rem;
            r_root[k] <= n_root;
            r_sat[k]  <= w_sat;
        end
    end

    assign o_side = r_side[RW-1];
    assign o_root = r_root[RW-1];
    assign o_sat  = r_sat[RW-1];

endmodule

[hdl/line_line_distance_3d.sv]
`timescale 1ns / 1ps
// Throughput: one item per cycle; busy is always low, the pipeline never stalls.
// Most of the depth lies in the 65-stage divider and the 32-stage square root.
// Reset (synchronous, active low) clears all valid bits; items in flight are dropped.
// Results cannot be held off by the receiver: each is shown for exactly one cycle.
module line_line_distance_3d (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  lld_pkg::t_item     i_item,
    output logic               o_valid,
    output lld_pkg::t_result   o_result
);
    localparam int CW     = lld_pkg::COORD_W;
    localparam int DFW    = lld_pkg::DIFF_W;
    localparam int XW     = lld_pkg::CROSS_W;
    localparam int MW     = lld_pkg::MUL_W;
    localparam int PW     = lld_pkg::PROD_W;
    localparam int DW     = lld_pkg::DEN_W;
    localparam int ML     = lld_pkg::MUL_LAT;
    localparam int DL_LEN = lld_pkg::DOT_LAT + lld_pkg::MUL_LAT;

    logic w_accept;
    logic signed [CW-1:0] w_p1 [3];
    logic signed [CW-1:0] w_u1 [3];
    logic signed [CW-1:0] w_p2 [3];
    logic signed [CW-1:0] w_u2 [3];

    assign busy     = 1'b0;
    assign w_accept = start & ~busy;

    assign w_p1[0] = i_item.first_point_x;
    assign w_p1[1] = i_item.first_point_y;
    assign w_p1[2] = i_item.first_point_z;
    assign w_u1[0] = i_item.first_dir_x;
    assign w_u1[1] = i_item.first_dir_y;
    assign w_u1[2] = i_item.first_dir_z;
    assign w_p2[0] = i_item.second_point_x;
    assign w_p2[1] = i_item.second_point_y;
    assign w_p2[2] = i_item.second_point_z;
    assign w_u2[0] = i_item.second_dir_x;
    assign w_u2[1] = i_item.second_dir_y;
    assign w_u2[2] = i_item.second_dir_z;

    // Stage 1: point difference.
    logic                  r_v1;
    logic signed [DFW-1:0] r_d1  [3];
    logic signed [CW-1:0]  r_u1_1 [3];
    logic signed [CW-1:0]  r_u2_1 [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= w_accept;
        end
        for (int i = 0; i < 3; i++) begin
            r_d1[i]   <= DFW'(w_p1[i]) - DFW'(w_p2[i]);
            r_u1_1[i] <= w_u1[i];
            r_u2_1[i] <= w_u2[i];
        end
    end

    // Stage 2: the six products of the cross product.
    logic                   r_v2;
    logic signed [2*CW-1:0] r_t [3];
    logic signed [2*CW-1:0] r_s [3];
    logic signed [DFW-1:0]  r_d2  [3];
    logic signed [CW-1:0]   r_u2_2 [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
        r_t[0] <= r_u1_1[1] * r_u2_1[2];
        r_s[0] <= r_u1_1[2] * r_u2_1[1];
        r_t[1] <= r_u1_1[2] * r_u2_1[0];
        r_s[1] <= r_u1_1[0] * r_u2_1[2];
        r_t[2] <= r_u1_1[0] * r_u2_1[1];
        r_s[2] <= r_u1_1[1] * r_u2_1[0];
        r_d2   <= r_d1;
        r_u2_2 <= r_u2_1;
    end

    // Stage 3: cross product and the parallel flag.
    logic signed [XW-1:0]  w_c [3];
    logic                  r_v3;
    logic                  r_par3;
    logic signed [XW-1:0]  r_c3  [3];
    logic signed [DFW-1:0] r_d3  [3];
    logic signed [CW-1:0]  r_u2_3 [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_c[i] = XW'(r_t[i]) - XW'(r_s[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else begin
            r_v3 <= r_v2;
        end
        r_par3 <= (w_c[0] == '0) && (w_c[1] == '0) && (w_c[2] == '0);
        r_c3   <= w_c;
        r_d3   <= r_d2;
        r_u2_3 <= r_u2_2;
    end

    // Dot products. Skew lines: X = d.C and Y = C.C. Parallel lines: X = u2.d,
    // Y = u2.u2 and Z = d.d.
    lld_pkg::t_mop  w_xa [3];
    lld_pkg::t_mop  w_xb [3];
    lld_pkg::t_mop  w_ya [3];
    lld_pkg::t_mop  w_za [3];
    lld_pkg::t_prod w_x;
    lld_pkg::t_prod w_y;
    lld_pkg::t_prod w_z;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_xa[i] = r_par3 ? MW'(r_u2_3[i]) : MW'(r_d3[i]);
            w_xb[i] = r_par3 ? MW'(r_d3[i])   : MW'(r_c3[i]);
            w_ya[i] = r_par3 ? MW'(r_u2_3[i]) : MW'(r_c3[i]);
            w_za[i] = MW'(r_d3[i]);
        end
    end

    lld_dot u_dot_x (.i_clk(i_clk), .i_a(w_xa), .i_b(w_xb), .o_dot(w_x));
    lld_dot u_dot_y (.i_clk(i_clk), .i_a(w_ya), .i_b(w_ya), .o_dot(w_y));
    lld_dot u_dot_z (.i_clk(i_clk), .i_a(w_za), .i_b(w_za), .o_dot(w_z));

    // Second products: X*X is the squared triple product or P*P, Z*Y is D2*U2.
    lld_pkg::t_prod w_ma;
    lld_pkg::t_prod w_mb;

    lld_mul u_mul_a (
        .i_clk (i_clk),
        .i_a   (w_x[MW-1:0]),
        .i_b   (w_x[MW-1:0]),
        .o_p   (w_ma)
    );

    lld_mul u_mul_b (
        .i_clk (i_clk),
        .i_a   (w_z[MW-1:0]),
        .i_b   (w_y[MW-1:0]),
        .o_p   (w_mb)
    );

    lld_pkg::t_side r_side_dl [DL_LEN];
    logic [DW-1:0]  r_y_dl    [ML];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DL_LEN; k++) begin
                r_side_dl[k] <= '0;
            end
        end else begin
            r_side_dl[0] <= '{valid: r_v3, par: r_par3};
            for (int k = 1; k < DL_LEN; k++) begin
                r_side_dl[k] <= r_side_dl[k-1];
            end
        end
        r_y_dl[0] <= w_y[DW-1:0];
        for (int k = 1; k < ML; k++) begin
            r_y_dl[k] <= r_y_dl[k-1];
        end
    end

    // Numerator and denominator of the squared distance.
    lld_pkg::t_prod w_diff;
    logic [PW-1:0]  n_num;
    logic [DW-1:0]  n_den;
    logic [PW-1:0]  r_num;
    logic [DW-1:0]  r_den;
    lld_pkg::t_side r_side_nm;

    always_comb begin
        w_diff = w_mb - w_ma;
        n_num  = w_ma;
        n_den  = r_y_dl[ML-1];
        if (r_side_dl[DL_LEN-1].par) begin
            if (r_y_dl[ML-1] == '0) begin
                // A null second direction gives a zero distance.
                n_num = '0;
                n_den = DW'(1);
            end else if (w_diff[PW-1]) begin
                n_num = '0;
            end else begin
                n_num = w_diff;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side_nm <= '0;
        end else begin
            r_side_nm <= r_side_dl[DL_LEN-1];
        end
        r_num <= n_num;
        r_den <= n_den;
    end

    lld_pkg::t_side              w_div_side;
    logic [lld_pkg::QUO_W-1:0]   w_quo;
    logic                        w_div_sat;

    lld_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_side  (r_side_nm),
        .i_num   (r_num),
        .i_den   (r_den),
        .o_side  (w_div_side),
        .o_quo   (w_quo),
        .o_sat   (w_div_sat)
    );

    lld_pkg::t_side              w_sq_side;
    logic [lld_pkg::ROOT_W-1:0]  w_root;
    logic                        w_sq_sat;

    lld_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_side  (w_div_side),
        .i_val   (w_quo),
        .i_sat   (w_div_sat),
        .o_side  (w_sq_side),
        .o_root  (w_root),
        .o_sat   (w_sq_sat)
    );

    logic             r_valid;
    lld_pkg::t_result r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_sq_side.valid;
        end
        r_result.line_gap       <= w_sq_sat ? '1 : lld_pkg::GAP_W'(w_root);
        r_result.lines_parallel <= w_sq_side.par;
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

[tb/line_line_distance_3d_tb.sv]
`timescale 1ns / 1ps

module line_line_distance_3d_tb;

    localparam int  DRAIN_CYCLES = 140;
    localparam int  STALL_LIMIT  = 1000;
    localparam int  RANDOM_ITEMS = 830;

    typedef logic signed [299:0] t_wide;

    logic             i_clk;
    logic             i_rst_n;
    logic             start;
    logic             busy;
    lld_pkg::t_item   i_item;
    logic             o_valid;
    lld_pkg::t_result o_result;

    lld_pkg::t_item   pending_items[$];
    lld_pkg::t_result expected_gaps[$];
    int      mismatch_count;
    int      stall_cycles;
    int      items_sent;
    logic    in_reset;

    line_line_distance_3d i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    function automatic t_wide dot3(input t_wide a[3], input t_wide b[3]);
        return a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
    endfunction

    function automatic t_wide floor_sqrt(input t_wide n);
        t_wide root;
        t_wide trial;
        root = '0;
        for (int i = 149; i >= 0; i--) begin
            trial = root | (t_wide'(1) << i);
            if (trial * trial <= n) begin
                root = trial;
            end
        end
        return root;
    endfunction

    // Exact integer geometry: every intermediate fits well inside 300 bits.
    function automatic lld_pkg::t_result predict_gap(input lld_pkg::t_item it);
        t_wide   p1[3], u1[3], p2[3], u2[3], d[3], c[3];
        t_wide   num, den, uu, root;
        logic    par;
        lld_pkg::t_result res;
        p1[0] = it.first_point_x;   p1[1] = it.first_point_y;   p1[2] = it.first_point_z;
        u1[0] = it.first_dir_x;     u1[1] = it.first_dir_y;     u1[2] = it.first_dir_z;
        p2[0] = it.second_point_x;  p2[1] = it.second_point_y;  p2[2] = it.second_point_z;
        u2[0] = it.second_dir_x;    u2[1] = it.second_dir_y;    u2[2] = it.second_dir_z;
        for (int i = 0; i < 3; i++) begin
            d[i] = p1[i] - p2[i];
        end
        for (int i = 0; i < 3; i++) begin
            c[i] = u1[(i + 1) % 3] * u2[(i + 2) % 3] - u1[(i + 2) % 3] * u2[(i + 1) % 3];
        end
        par  = (c[0] == 0) && (c[1] == 0) && (c[2] == 0);
        root = '0;
        if (!par) begin
            num  = dot3(d, c);
            den  = dot3(c, c);
            root = floor_sqrt((num * num) / den);
        end else begin
            uu = dot3(u2, u2);
            if (uu != 0) begin
                num = dot3(d, d) * uu - dot3(u2, d) * dot3(u2, d);
                if (num < 0) begin
                    num = '0;
                end
                root = floor_sqrt(num / uu);
            end
        end
        res.line_gap       = (root > 300'sh0FFFFFFFF) ? 32'hFFFFFFFF : root[31:0];
        res.lines_parallel = par;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input lld_pkg::t_result got,
                                   input lld_pkg::t_result want);
        $display("MISMATCH %s: got gap %h par %b, expected gap %h par %b at %0t",
                 what, got.line_gap, got.lines_parallel, want.line_gap,
                 want.lines_parallel, $realtime);
        mismatch_count++;
    endtask

    function automatic logic signed [31:0] small_coord(input int span);
        return $signed(32'($urandom_range(2 * span))) - span;
    endfunction

    function automatic lld_pkg::t_item random_item();
        lld_pkg::t_item it;
        int    k;
        int    shape;
        it    = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        shape = $urandom_range(9);
        if (shape >= 3) begin
            // Moderate coordinates so that the distance usually fits.
            it.first_point_x  = small_coord(1 << 22);
            it.first_point_y  = small_coord(1 << 22);
            it.first_point_z  = small_coord(1 << 22);
            it.second_point_x = small_coord(1 << 22);
            it.second_point_y = small_coord(1 << 22);
            it.second_point_z = small_coord(1 << 22);
            it.second_dir_x   = small_coord(1 << 18);
            it.second_dir_y   = small_coord(1 << 18);
            it.second_dir_z   = small_coord(1 << 18);
            it.first_dir_x    = small_coord(1 << 18);
            it.first_dir_y    = small_coord(1 << 18);
            it.first_dir_z    = small_coord(1 << 18);
        end
        if (shape >= 6) begin
            // Parallel directions: the first is a scaled copy of the second.
            it.second_dir_x = small_coord(1 << 12);
            it.second_dir_y = small_coord(1 << 12);
            it.second_dir_z = small_coord(1 << 12);
            k = $urandom_range(64) - 32;
            it.first_dir_x  = it.second_dir_x * k;
            it.first_dir_y  = it.second_dir_y * k;
            it.first_dir_z  = it.second_dir_z * k;
            if (shape == 9) begin
                it.second_dir_x = '0;
                it.second_dir_y = '0;
                it.second_dir_z = '0;
            end
        end else if (shape == 5) begin
            // Intersecting lines: both pass through the first point.
            it.second_point_x = it.first_point_x;
            it.second_point_y = it.first_point_y;
            it.second_point_z = it.first_point_z;
        end
        return it;
    endfunction

    // Driver: presents the head of the queue and pops it on acceptance.
    always @(posedge i_clk) begin
        if (in_reset) begin
            start  <= 1'b0;
            i_item <= '0;
        end else begin
            if (start && !busy) begin
                expected_gaps.push_back(predict_gap(i_item));
                void'(pending_items.pop_front());
                items_sent++;
            end
            if (pending_items.size() > 0 &&
                ((items_sent > 300 && items_sent < 460) || $urandom_range(99) >= 11)) begin
                start  <= 1'b1;
                i_item <= pending_items[0];
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Monitor and watchdog.
    always @(posedge i_clk) begin
        if (!in_reset) begin
            if (o_valid) begin
                if (expected_gaps.size() == 0) begin
                    report_mismatch("unexpected result", o_result, '0);
                end else begin
                    if (o_result.line_gap !== expected_gaps[0].line_gap) begin
                        report_mismatch("line_gap", o_result, expected_gaps[0]);
                    end
                    if (o_result.lines_parallel !== expected_gaps[0].lines_parallel) begin
                        report_mismatch("lines_parallel", o_result, expected_gaps[0]);
                    end
                    void'(expected_gaps.pop_front());
                end
            end
            if (o_valid || (start && !busy)) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= STALL_LIMIT) begin
                $display("line_line_distance_3d regression: fail");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    initial begin
        lld_pkg::t_item it;
        mismatch_count = 0;
        items_sent     = 0;
        stall_cycles   = 0;
        in_reset       = 1'b1;
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_item         = '0;

        // Directed items.
        pending_items.push_back('0);
        pending_items.push_back({12{32'h7FFFFFFF}});
        pending_items.push_back({12{32'h80000000}});
        pending_items.push_back({12{32'hFFFFFFFF}});
        // Perpendicular axes far apart: the gap is the largest 32-bit value.
        it = '0;
        it.first_point_z = 32'sh7FFFFFFF;  it.first_dir_x  = 32'sh00010000;
        it.second_point_z = 32'sh80000000; it.second_dir_y = 32'sh00010000;
        pending_items.push_back(it);
        // Perpendicular axes 0x20000 apart.
        it.first_point_z = 32'sh00010000;  it.second_point_z = -32'sh00010000;
        pending_items.push_back(it);
        // Null second direction, nonzero first: parallel with zero gap.
        it.second_dir_y = '0;
        pending_items.push_back(it);
        // Null first direction: parallel, point-to-line distance.
        it = '0;
        it.first_point_x = 32'sh00030000; it.second_dir_z = 32'sh00010000;
        pending_items.push_back(it);
        // Parallel lines with extreme directions and points.
        it = '0;
        it.first_dir_x  = 32'sh80000000; it.second_dir_x = 32'sh7FFFFFFF;
        it.first_point_y = 32'sh7FFFFFFF; it.second_point_y = 32'sh80000000;
        pending_items.push_back(it);
        // Same line twice.
        it = '0;
        it.first_dir_x = 32'sh00010000; it.first_dir_y = 32'sh00020000;
        it.second_dir_x = 32'sh00010000; it.second_dir_y = 32'sh00020000;
        it.first_point_x = 32'sh00010000; it.second_point_x = 32'sh00020000;
        it.second_point_y = 32'sh00020000;
        pending_items.push_back(it);
        // Intersecting, non-parallel lines.
        it.second_dir_y = -32'sh00020000;
        it.second_point_x = it.first_point_x; it.second_point_y = it.first_point_y;
        pending_items.push_back(it);
        // Extreme directions on skew lines.
        it = {32'sh7FFFFFFF, 32'sh80000000, 32'sh0, 32'sh80000000, 32'sh7FFFFFFF,
              32'sh1, 32'sh80000000, 32'sh7FFFFFFF, 32'sh0, 32'sh7FFFFFFF,
              32'sh80000000, 32'sh80000000};
        pending_items.push_back(it);
        for (int i = 0; i < 8; i++) begin
            pending_items.push_back(random_item());
        end
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            pending_items.push_back(random_item());
        end

        repeat (9) @(posedge i_clk);
        i_rst_n  <= 1'b1;
        in_reset <= 1'b0;

        wait (pending_items.size() == 0 && expected_gaps.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && expected_gaps.size() == 0) begin
            $display("line_line_distance_3d regression: pass");
        end else begin
            $display("line_line_distance_3d regression: fail");
        end
        $finish;
    end

endmodule

[filelist.f]
hdl/lld_pkg.sv
hdl/lld_mul.sv
hdl/lld_dot.sv
hdl/lld_div.sv
hdl/lld_sqrt.sv
hdl/line_line_distance_3d.sv
tb/line_line_distance_3d_tb.sv
